[src/loop_current_piecewise_calibration_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the loop current calibration block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef LOOP_CURRENT_PIECEWISE_CALIBRATION_TOP_MACROS_SVH
`define LOOP_CURRENT_PIECEWISE_CALIBRATION_TOP_MACROS_SVH
`ifndef SYNTH
`define LCPC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lcpc assertion failed");
`define LCPC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lcpc assertion failed");
`else
`define LCPC_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define LCPC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[src/lcpc_pkg.sv]
// ----------------------------------------------------------------------------
// lcpc_pkg
// Shared constants, codes and types of the loop current calibration block.
// ----------------------------------------------------------------------------
package lcpc_pkg;
	localparam int CAL_POINTS_DEF = 5;
	localparam int SAMPLE_W       = 16;
	localparam int IDX_W          = 3;
	localparam int NUM_W          = 40;
	localparam int DEN_W          = 17;
	localparam int DVD_W          = 41;
	localparam int REM_W          = 17;
	localparam int FIFO_DEPTH     = 4;

	localparam logic signed [SAMPLE_W-1:0] ABSENT_MARK = 16'sh8000;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [IDX_W-1:0] REG_4MA  = 3'd0;
	localparam logic [IDX_W-1:0] REG_8MA  = 3'd1;
	localparam logic [IDX_W-1:0] REG_12MA = 3'd2;
	localparam logic [IDX_W-1:0] REG_16MA = 3'd3;
	localparam logic [IDX_W-1:0] REG_20MA = 3'd4;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} lcpc_item_t;

	// milliamps belonging to a calibration slot: 4 * (slot + 1)
	function automatic logic [4:0] slot_ma(input logic [IDX_W-1:0] k);
		return 5'({k, 2'b00}) + 5'd4;
	endfunction
endpackage

[src/lcpc_front.sv]
// ----------------------------------------------------------------------------
// lcpc_front
// Holds the calibration points, picks the segment and forms the division.
// ----------------------------------------------------------------------------
module lcpc_front #(
	parameter int CAL_POINTS = lcpc_pkg::CAL_POINTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [lcpc_pkg::IDX_W-1:0]              cfg_index,
	input  logic [lcpc_pkg::SAMPLE_W-1:0]           cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [lcpc_pkg::SAMPLE_W-1:0]    raw_sample,
	input  logic                                    q_full,
	output logic                                    q_push,
	output lcpc_pkg::lcpc_item_t                    q_item,
	output logic                                    busy
);
	import lcpc_pkg::*;

	logic signed [SAMPLE_W-1:0] cal_q [5];
	logic [4:0]                 present;
	logic [IDX_W-1:0]           lo_sel, hi_sel;
	logic                       below;

	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] raw_s1, rlo_s1, rhi_s1, r0_s1;
	logic [4:0]                 mlo_s1, mhi_s1;
	logic                       below_s1;
	logic                       adv;

	logic signed [DEN_W-1:0]    den_lin, dif;
	logic signed [22:0]         p1, p2, psum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q[0] <= 16'sd1000;
			cal_q[1] <= ABSENT_MARK;
			cal_q[2] <= ABSENT_MARK;
			cal_q[3] <= ABSENT_MARK;
			cal_q[4] <= 16'sd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_4MA:  cal_q[0] <= cfg_data;
				REG_8MA:  cal_q[1] <= cfg_data;
				REG_12MA: cal_q[2] <= cfg_data;
				REG_16MA: cal_q[3] <= cfg_data;
				REG_20MA: cal_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// end points always count; optional ones only within the slot budget
	always_comb begin
		logic             found;
		logic             ext;
		logic [IDX_W-1:0] prev;
		present = 5'b10001;
		for (int k = 1; k < 4; k++) begin
			present[k] = ((k - 1) < (CAL_POINTS - 2)) && (cal_q[k] != ABSENT_MARK);
		end
		ext    = raw_sample > cal_q[4];
		found  = 1'b0;
		prev   = REG_4MA;
		lo_sel = REG_4MA;
		hi_sel = REG_20MA;
		for (int k = 1; k < 5; k++) begin
			if (present[k]) begin
				// past the last point only the last segment applies
				if (!found && (k == 4 || (!ext && raw_sample <= cal_q[k]))) begin
					found  = 1'b1;
					lo_sel = prev;
					hi_sel = 3'(k);
				end
				prev = 3'(k);
			end
		end
		below = raw_sample < cal_q[0];
	end

	assign adv      = !v_s1 || !q_full;
	assign q_push   = v_s1 && !q_full;
	assign in_stall = v_s1 && q_full;
	assign busy     = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			raw_s1   <= raw_sample;
			rlo_s1   <= cal_q[lo_sel];
			rhi_s1   <= cal_q[hi_sel];
			r0_s1    <= cal_q[0];
			mlo_s1   <= slot_ma(lo_sel);
			mhi_s1   <= slot_ma(hi_sel);
			below_s1 <= below;
		end
	end

	// numerator: mlo*den*2^16 + (raw-rlo)*(mhi-mlo)*2^16, or raw*2^18 if below
	always_comb begin
		den_lin = DEN_W'(rhi_s1) - DEN_W'(rlo_s1);
		dif     = DEN_W'(raw_s1) - DEN_W'(rlo_s1);
		p1      = 23'(den_lin) * 23'(signed'({1'b0, mlo_s1}));
		p2      = 23'(dif) * 23'(signed'({1'b0, mhi_s1 - mlo_s1}));
		psum    = p1 + p2;
		if (below_s1) begin
			q_item.num = NUM_W'(raw_s1) <<< 18;
			q_item.den = DEN_W'(r0_s1);
		end else begin
			q_item.num = NUM_W'(psum) <<< 16;
			q_item.den = den_lin;
		end
	end
endmodule

[src/lcpc_fifo.sv]
// ----------------------------------------------------------------------------
// lcpc_fifo
// Short queue of division jobs between the front and the divider.
// ----------------------------------------------------------------------------
module lcpc_fifo #(
	parameter int DEPTH = lcpc_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcpc_pkg::lcpc_item_t item_in,
	output logic                 full,
	input  logic                 pop,
	output lcpc_pkg::lcpc_item_t item_out,
	output logic                 not_empty
);
	import lcpc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcpc_item_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign item_out  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= item_in;
		end
	end
endmodule

[src/lcpc_back.sv]
// ----------------------------------------------------------------------------
// lcpc_back
// Pipelined rounding divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module lcpc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  lcpc_pkg::lcpc_item_t        q_item,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          current_q16,
	output logic [1:0]                  status,
	output logic                        busy
);
	import lcpc_pkg::*;

	logic                adv;
	logic                v_sd    [DVD_W+1];
	logic [DVD_W-1:0]    dvd_sd  [DVD_W+1];
	logic [REM_W-1:0]    rem_sd  [DVD_W+1];
	logic [REM_W-1:0]    dv_sd   [DVD_W+1];
	logic                neg_sd  [DVD_W+1];
	logic                zero_sd [DVD_W+1];

	logic [NUM_W-1:0]    an;
	logic [15:0]         ad;
	logic                out_valid_q;
	logic signed [31:0]  cur_q;
	logic [1:0]          st_q;
	logic [DVD_W-1:0]    qf;
	logic                sat;
	logic [31:0]         qv;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	// q = (2|n| + |d|) / (2|d|) rounds half away from zero
	always_comb begin
		an = q_item.num[NUM_W-1] ? NUM_W'(-q_item.num) : NUM_W'(q_item.num);
		ad = q_item.den[DEN_W-1] ? 16'(-q_item.den) : 16'(q_item.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DVD_W; k++) begin
				v_sd[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_sd[0] <= q_valid;
			for (int k = 1; k <= DVD_W; k++) begin
				v_sd[k] <= v_sd[k-1];
			end
			out_valid_q <= v_sd[DVD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_sd[0]  <= (DVD_W'(an) << 1) + DVD_W'(ad);
			rem_sd[0]  <= '0;
			dv_sd[0]   <= REM_W'(ad) << 1;
			neg_sd[0]  <= q_item.num[NUM_W-1] ^ q_item.den[DEN_W-1];
			zero_sd[0] <= q_item.den == '0;
		end
	end

	for (genvar g = 0; g < DVD_W; g++) begin : g_div
		logic [REM_W:0] trial;
		logic           ge;
		assign trial = {rem_sd[g], dvd_sd[g][DVD_W-1]};
		assign ge    = trial >= {1'b0, dv_sd[g]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[g+1]  <= ge ? REM_W'(trial - {1'b0, dv_sd[g]}) : REM_W'(trial);
				dvd_sd[g+1]  <= {dvd_sd[g][DVD_W-2:0], ge};
				dv_sd[g+1]   <= dv_sd[g];
				neg_sd[g+1]  <= neg_sd[g];
				zero_sd[g+1] <= zero_sd[g];
			end
		end
	end

	always_comb begin
		qf  = dvd_sd[DVD_W];
		sat = neg_sd[DVD_W] ? (qf > DVD_W'(64'h8000_0000))
		                    : (qf > DVD_W'(64'h7FFF_FFFF));
		qv  = neg_sd[DVD_W] ? 32'(-qf) : 32'(qf);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_sd[DVD_W]) begin
				cur_q <= '0;
				st_q  <= ST_ZERO;
			end else if (sat) begin
				cur_q <= neg_sd[DVD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				st_q  <= ST_SAT;
			end else begin
				cur_q <= signed'(qv);
				st_q  <= ST_OK;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign current_q16 = cur_q;
	assign status      = st_q;
	assign busy        = v_sd[0];
endmodule

[src/loop_current_piecewise_calibration_top.sv]
// Path from an accepted sample to its result: front register, queue,
// divider set-up, 41 one-bit divider stages, output register.
// Throughput: one sample per cycle unless out_stall holds the pipeline.
// Reset: asynchronous, active low; calibration points return to 1000/5000
// with the middle points absent, all pipelines and the queue empty.
`include "loop_current_piecewise_calibration_top_macros.svh"
// ----------------------------------------------------------------------------
// loop_current_piecewise_calibration_top
// Shunt sample to 4-20 mA loop current by piecewise linear calibration.
// ----------------------------------------------------------------------------
module loop_current_piecewise_calibration_top #(
	parameter int CAL_POINTS = lcpc_pkg::CAL_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lcpc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [lcpc_pkg::SAMPLE_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [lcpc_pkg::SAMPLE_W-1:0] raw_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   current_q16,
	output logic [1:0]                           status
);
	import lcpc_pkg::*;

	lcpc_item_t push_item, pop_item;
	logic       q_push, q_full, q_pop, q_nempty;
	logic       front_busy, back_busy;

	lcpc_front #(.CAL_POINTS(CAL_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .raw_sample(raw_sample),
		.q_full(q_full), .q_push(q_push), .q_item(push_item), .busy(front_busy)
	);

	lcpc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .item_in(push_item), .full(q_full),
		.pop(q_pop), .item_out(pop_item), .not_empty(q_nempty)
	);

	lcpc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_nempty), .q_item(pop_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.current_q16(current_q16), .status(status), .busy(back_busy)
	);

	`LCPC_ASSERT_NEXT(a_front_takes, clk, arst_n, in_valid && !in_stall, front_busy)
	`LCPC_ASSERT_NEXT(a_back_takes, clk, arst_n, q_pop, back_busy)
	`LCPC_ASSERT_IMPLIES(a_zero_div, clk, arst_n, out_valid && status == ST_ZERO, current_q16 == 32'sd0)
	`LCPC_ASSERT_IMPLIES(a_sat_limit, clk, arst_n, out_valid && status == ST_SAT, current_q16 == 32'sh7FFF_FFFF || current_q16 == 32'sh8000_0000)
endmodule
